### hdl/lpt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, operation codes and control types for the LRU page table.
package lpt_pkg;

	localparam int MAX_PAGES_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int ID_W          = 16;
	localparam int VAL_W         = 32;
	localparam int STAMP_W       = 32;

	localparam logic [CFG_W-1:0]   PAGES_RESET = 5'd16;
	localparam logic [STAMP_W-1:0] CLOCK_RESET = 32'd1;
	localparam logic [VAL_W-1:0]   MISS_VALUE  = 32'hFFFF_FFFF;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_GET    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_SWAP   = 2'd3;

	// Write side controls of the entry store.
	typedef struct packed {
		logic entry_we;  // write id, value and stamp
		logic stamp_we;  // write stamp only
		logic vld_set;   // mark the entry valid
		logic vld_clr;   // mark the entry empty
	} store_ctl_t;

endpackage

### hdl/lru_page_table_unit.sv
`timescale 1ns / 1ps
// Top level of the fully associative LRU page table with its scan sequencer.
// busy stays high after acceptance until the result strobe; a new command is accepted only while idle.
// The scan reads one entry a cycle from the store through one compare unit.
// Reset (arst_n low) empties every entry, sets the page count to 16 and the access clock to one.
// Results are shown for exactly one cycle with done high; the receiver cannot stall.
module lru_page_table_unit #(
	parameter int MAX_PAGES = lpt_pkg::MAX_PAGES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: page count register.
	input  logic                              cfg_wr_en,
	input  logic [lpt_pkg::CFG_W-1:0]         cfg_wr_data,
	// Command beat.
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [lpt_pkg::ID_W-1:0]          var_id,
	input  logic signed [lpt_pkg::VAL_W-1:0]  value,
	// Result beat.
	output logic                              done,
	output logic                              found,
	output logic signed [lpt_pkg::VAL_W-1:0]  read_value,
	output logic [lpt_pkg::ID_W-1:0]          evicted_id,
	output logic signed [lpt_pkg::VAL_W-1:0]  evicted_value,
	output logic                              full_res
);

	localparam int IDX_W  = $clog2(MAX_PAGES);
	localparam int CNT_W  = $clog2(MAX_PAGES + 1);
	localparam int WIDE_W = (CNT_W > lpt_pkg::CFG_W) ? CNT_W : lpt_pkg::CFG_W;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_COMMIT = 2'd3;

	logic [1:0]                    state_q;
	logic [lpt_pkg::CFG_W-1:0]     pages_q;
	logic [lpt_pkg::STAMP_W-1:0]   clock_q;

	// Latched command.
	logic [1:0]                    op_q;
	logic [lpt_pkg::ID_W-1:0]      id_q;
	logic [lpt_pkg::VAL_W-1:0]     val_q;

	// Scan address and the pipeline stage that follows the memory read.
	logic [IDX_W-1:0]              idx_q;
	logic [IDX_W-1:0]              last_q;
	logic                          chk_s1;
	logic [IDX_W-1:0]              idx_s1;

	// Scan results.
	logic                          hit_q;
	logic [IDX_W-1:0]              sel_idx_q;
	logic                          sel_vld_q;
	logic [lpt_pkg::ID_W-1:0]      sel_id_q;
	logic [lpt_pkg::VAL_W-1:0]     sel_val_q;
	logic [lpt_pkg::STAMP_W-1:0]   oldest_q;
	logic [1:0]                    inv_cnt_q;

	// Store interface.
	logic [lpt_pkg::ID_W-1:0]      rd_id;
	logic [lpt_pkg::VAL_W-1:0]     rd_value;
	logic [lpt_pkg::STAMP_W-1:0]   rd_stamp;
	logic                          rd_vld;
	logic [IDX_W-1:0]              wr_addr;
	lpt_pkg::store_ctl_t           ctl;

	// Shared compare unit: id equality and unsigned stamp ordering for the entry
	// coming out of the store this cycle.
	logic                          id_match;
	logic [lpt_pkg::STAMP_W-1:0]   stamp_eff;
	logic                          stamp_older;
	logic                          now_invalid;

	// Clamped last scan index taken from the page count register.
	logic [WIDE_W-1:0]             pages_wide;
	logic [IDX_W-1:0]              last_idx;

	logic                          accept;
	logic                          full_next;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign pages_wide = WIDE_W'(pages_q);

	always_comb begin
		if (pages_q == '0) begin
			last_idx = '0;
		end else if (pages_wide > WIDE_W'(MAX_PAGES)) begin
			last_idx = IDX_W'(MAX_PAGES - 1);
		end else begin
			last_idx = IDX_W'(pages_wide - WIDE_W'(1));
		end
	end

	assign id_match    = rd_vld && (rd_id == id_q);
	assign stamp_eff   = rd_vld ? rd_stamp : '0;
	assign stamp_older = (idx_s1 == '0) || (stamp_eff < oldest_q);
	assign now_invalid = !rd_vld || ((op_q == lpt_pkg::OP_REMOVE) && id_match);

	// Whether every used entry is valid once the operation has taken effect.
	// An add fills one hole, a swap fills one only when it picked an empty entry.
	always_comb begin
		case (op_q)
			lpt_pkg::OP_ADD:  full_next = (inv_cnt_q != 2'd2);
			lpt_pkg::OP_SWAP: full_next = (inv_cnt_q == 2'd0) ||
				((inv_cnt_q == 2'd1) && !sel_vld_q);
			default:          full_next = (inv_cnt_q == 2'd0);
		endcase
	end

	// Store write controls: removal clears during the scan, the commit writes once.
	always_comb begin
		ctl     = '0;
		wr_addr = sel_idx_q;
		if (state_q == ST_COMMIT) begin
			case (op_q)
				lpt_pkg::OP_ADD: begin
					ctl.entry_we = hit_q;
					ctl.vld_set  = hit_q;
				end
				lpt_pkg::OP_GET: begin
					ctl.stamp_we = hit_q;
				end
				lpt_pkg::OP_SWAP: begin
					ctl.entry_we = 1'b1;
					ctl.vld_set  = 1'b1;
				end
				default: begin
					ctl = '0;
				end
			endcase
		end else if (chk_s1 && (op_q == lpt_pkg::OP_REMOVE) && id_match) begin
			ctl.vld_clr = 1'b1;
			wr_addr     = idx_s1;
		end
	end

	lpt_entry_store #(
		.MAX_PAGES (MAX_PAGES),
		.IDX_W     (IDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (idx_q),
		.rd_id    (rd_id),
		.rd_value (rd_value),
		.rd_stamp (rd_stamp),
		.rd_vld   (rd_vld),
		.wr_addr  (wr_addr),
		.ctl      (ctl),
		.wr_id    (id_q),
		.wr_value (val_q),
		.wr_stamp (clock_q)
	);

	// Page count register; to be written only while the block is idle, which the block itself does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pages_q <= lpt_pkg::PAGES_RESET;
		end else if (cfg_wr_en) begin
			pages_q <= cfg_wr_data;
		end
	end

	// Sequencer: scan every used entry, let the last read drain, then commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			chk_s1    <= 1'b0;
			hit_q     <= 1'b0;
			inv_cnt_q <= 2'd0;
			clock_q   <= lpt_pkg::CLOCK_RESET;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					chk_s1 <= 1'b0;
					if (accept) begin
						state_q   <= ST_SCAN;
						idx_q     <= '0;
						hit_q     <= 1'b0;
						inv_cnt_q <= 2'd0;
					end
				end
				ST_SCAN: begin
					chk_s1 <= 1'b1;
					if (idx_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					chk_s1  <= 1'b0;
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
					if ((op_q inside {lpt_pkg::OP_ADD, lpt_pkg::OP_SWAP}) ||
						((op_q == lpt_pkg::OP_GET) && hit_q)) begin
						clock_q <= clock_q + lpt_pkg::STAMP_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Evaluate the entry that left the store this cycle.
			if (chk_s1) begin
				if (now_invalid && (inv_cnt_q != 2'd2)) begin
					inv_cnt_q <= inv_cnt_q + 2'd1;
				end
				case (op_q)
					lpt_pkg::OP_ADD: begin
						if (!rd_vld && !hit_q) begin
							hit_q <= 1'b1;
						end
					end
					lpt_pkg::OP_GET: begin
						if (id_match && !hit_q) begin
							hit_q <= 1'b1;
						end
					end
					default: begin
						hit_q <= hit_q;
					end
				endcase
			end
		end
	end

	// Scan payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (accept) begin
			op_q   <= operation;
			id_q   <= var_id;
			val_q  <= value;
			last_q <= last_idx;
		end
		if (chk_s1) begin
			case (op_q)
				lpt_pkg::OP_ADD: begin
					if (!rd_vld && !hit_q) begin
						sel_idx_q <= idx_s1;
					end
				end
				lpt_pkg::OP_GET: begin
					if (id_match && !hit_q) begin
						sel_idx_q <= idx_s1;
						sel_val_q <= rd_value;
					end
				end
				lpt_pkg::OP_SWAP: begin
					// Strictly older wins, so ties keep the lower index.
					if (stamp_older) begin
						oldest_q  <= stamp_eff;
						sel_idx_q <= idx_s1;
						sel_vld_q <= rd_vld;
						sel_id_q  <= rd_id;
						sel_val_q <= rd_value;
					end
				end
				default: begin
					sel_idx_q <= sel_idx_q;
				end
			endcase
		end
	end

	// Result registers, loaded at commit and shown with the done strobe.
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT) begin
			found         <= (op_q == lpt_pkg::OP_GET) && hit_q;
			read_value    <= ((op_q == lpt_pkg::OP_GET) && hit_q) ?
				sel_val_q : lpt_pkg::MISS_VALUE;
			evicted_id    <= ((op_q == lpt_pkg::OP_SWAP) && sel_vld_q) ? sel_id_q : '0;
			evicted_value <= ((op_q == lpt_pkg::OP_SWAP) && sel_vld_q) ? sel_val_q : '0;
			full_res      <= full_next;
		end
	end

`ifndef NO_ASSERTIONS
	// An accepted command keeps the block busy in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("busy did not rise after a command was accepted");

	// A result is only shown once the sequencer has returned to idle.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while the sequencer is busy");

	// Each operation produces one single-cycle strobe.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// The strobe follows a commit and nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(state_q == ST_COMMIT))
		else $error("result strobe without a commit");
`endif

endmodule

### hdl/lpt_entry_store.sv
`timescale 1ns / 1ps
// Entry storage: id, value and stamp memories plus the valid flags.
module lpt_entry_store #(
	parameter int MAX_PAGES = lpt_pkg::MAX_PAGES_DEF,
	parameter int IDX_W     = $clog2(MAX_PAGES)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [IDX_W-1:0]                 rd_addr,
	output logic [lpt_pkg::ID_W-1:0]         rd_id,
	output logic [lpt_pkg::VAL_W-1:0]        rd_value,
	output logic [lpt_pkg::STAMP_W-1:0]      rd_stamp,
	output logic                             rd_vld,
	input  logic [IDX_W-1:0]                 wr_addr,
	input  lpt_pkg::store_ctl_t              ctl,
	input  logic [lpt_pkg::ID_W-1:0]         wr_id,
	input  logic [lpt_pkg::VAL_W-1:0]        wr_value,
	input  logic [lpt_pkg::STAMP_W-1:0]      wr_stamp
);

	logic [lpt_pkg::ID_W-1:0]    id_mem    [MAX_PAGES];
	logic [lpt_pkg::VAL_W-1:0]   value_mem [MAX_PAGES];
	logic [lpt_pkg::STAMP_W-1:0] stamp_mem [MAX_PAGES];
	logic [MAX_PAGES-1:0]        vld_q;

	// Memories: one write address, one read address with registered read data.
	always_ff @(posedge clk) begin
		if (ctl.entry_we) begin
			id_mem[wr_addr]    <= wr_id;
			value_mem[wr_addr] <= wr_value;
		end
		if (ctl.entry_we || ctl.stamp_we) begin
			stamp_mem[wr_addr] <= wr_stamp;
		end
		rd_id    <= id_mem[rd_addr];
		rd_value <= value_mem[rd_addr];
		rd_stamp <= stamp_mem[rd_addr];
	end

	// Valid flags are cleared by reset; an empty entry is never trusted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rd_vld <= 1'b0;
		end else begin
			if (ctl.vld_set) begin
				vld_q[wr_addr] <= 1'b1;
			end else if (ctl.vld_clr) begin
				vld_q[wr_addr] <= 1'b0;
			end
			rd_vld <= vld_q[rd_addr];
		end
	end

endmodule
